@@ rtl/buddy_block_allocator_macros.svh @@
// Assertion helpers for the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define BBA_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition always implies a consequence in the same cycle.
`define BBA_IMPLIES(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
package bba_pkg;

   localparam int ADDR_W   = 64;
   localparam int SIZE_W   = 17;
   localparam int CFG_ORD_W = 5;
   localparam int STATUS_W = 2;
   localparam int ORD_W    = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_BIG  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ORDER    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ORDER    = 2'd2;

   typedef logic [ORD_W-1:0] order_type;

endpackage

@@ rtl/bba_busy_ram.sv @@
// One busy flag per block, single write port and one registered read port.
module bba_busy_ram #(
   parameter int DEPTH_BITS = 11
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [DEPTH_BITS-1:0] wr_addr,
   input  logic                  wr_data,
   input  logic [DEPTH_BITS-1:0] rd_addr,
   output logic                  rd_data
);

   logic mem [2**DEPTH_BITS];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bba_stack_ram.sv @@
// Free stack storage for all orders, single write port and one registered read port.
module bba_stack_ram #(
   parameter int DEPTH_BITS = 11,
   parameter int WIDTH      = 16
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [DEPTH_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [DEPTH_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [2**DEPTH_BITS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/buddy_block_allocator.sv @@
// An allocation searches upward from the request order for a non-empty stack and splits the block
// down; a free merges level by level, scanning the buddy's free stack to take the buddy out.
// Throughput: one beat at a time; the next request is taken once the response is registered.
// Reset: synchronous, active high; a clearing pass over all 2^(OFFSET_BITS-SMALLEST_ORDER+1) busy
// flags then marks every block busy, and no request is taken until it finishes.
`include "buddy_block_allocator_macros.svh"

module buddy_block_allocator #(
   parameter int OFFSET_BITS    = 16,
   parameter int SMALLEST_ORDER = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request beats.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata, from bit 0: block_size [16:0], block_address [80:17], zero fill.
   input  logic [87:0]                      req_tdata,
   // tuser: command (0 allocate, 1 free).
   input  logic                             req_tuser,
   // Response beats.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: granted_address [63:0].
   output logic [bba_pkg::ADDR_W-1:0]       rsp_tdata,
   // tuser: status [1:0].
   output logic [bba_pkg::STATUS_W-1:0]     rsp_tuser,
   // Configuration write port.
   input  logic                             csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bba_pkg::ADDR_W-1:0]       csr_wdata
);

   // The block sizes live between SMALLEST_ORDER and OFFSET_BITS. Both memories are split
   // into one region per order, the region of order o holding 2^(OFFSET_BITS-o) entries.
   localparam int ORDER_COUNT = OFFSET_BITS - SMALLEST_ORDER + 1;
   localparam int IDX_W       = ORDER_COUNT;
   localparam int CNT_W       = ORDER_COUNT;
   localparam int CIDX_W      = $clog2(ORDER_COUNT + 1);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_SEARCH  = 4'd2;
   localparam logic [3:0] ST_POPRD   = 4'd3;
   localparam logic [3:0] ST_SPLITA  = 4'd4;
   localparam logic [3:0] ST_SPLITB  = 4'd5;
   localparam logic [3:0] ST_FREERD  = 4'd6;
   localparam logic [3:0] ST_FREECHK = 4'd7;
   localparam logic [3:0] ST_M0      = 4'd8;
   localparam logic [3:0] ST_M1      = 4'd9;
   localparam logic [3:0] ST_SCAN    = 4'd10;
   localparam logic [3:0] ST_SCANCHK = 4'd11;
   localparam logic [3:0] ST_TOPWR   = 4'd12;
   localparam logic [3:0] ST_MF1     = 4'd13;
   localparam logic [3:0] ST_MF2     = 4'd14;
   localparam logic [3:0] ST_RESP    = 4'd15;

   // First entry of the region that belongs to an order.
   function automatic logic [IDX_W-1:0] region_fn(input bba_pkg::order_type ord);
      logic [IDX_W:0] full;
      logic [IDX_W:0] span;
      full = (IDX_W+1)'(1) << IDX_W;
      span = (IDX_W+1)'(2) << (OFFSET_BITS - int'(ord));
      return IDX_W'(full - span);
   endfunction

   // Busy flag position of the block at an offset for an order.
   function automatic logic [IDX_W-1:0] bit_fn(input bba_pkg::order_type ord,
                                               input logic [OFFSET_BITS-1:0] off);
      return region_fn(ord) + IDX_W'(off >> ord);
   endfunction

   function automatic logic [CNT_W-1:0] blocks_fn(input bba_pkg::order_type ord);
      return CNT_W'(1) << (OFFSET_BITS - int'(ord));
   endfunction

   function automatic logic [bba_pkg::CFG_ORD_W:0] CFG_W_SO();
      return (bba_pkg::CFG_ORD_W+1)'(SMALLEST_ORDER);
   endfunction

   function automatic logic [bba_pkg::CFG_ORD_W:0] CFG_W_OB();
      return (bba_pkg::CFG_ORD_W+1)'(OFFSET_BITS);
   endfunction

   // Registers.
   logic [3:0]                   state_ff, state_in;
   logic [IDX_W-1:0]             clr_ff, clr_in;
   logic [bba_pkg::ADDR_W-1:0]   base_ff;
   logic [bba_pkg::CFG_ORD_W-1:0] min_ff, max_ff;
   bba_pkg::order_type           o_ff, o_in;
   bba_pkg::order_type           t_ff, t_in;
   bba_pkg::order_type           k_ff, k_in;
   logic [OFFSET_BITS-1:0]       off_ff, off_in;
   logic [CNT_W-1:0]             scan_ff, scan_in;
   logic [CNT_W-1:0]             cnt_ff [ORDER_COUNT];
   logic [bba_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [bba_pkg::ADDR_W-1:0]   grant_ff, grant_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bba_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;

   // Memory ports.
   logic                   busy_we, busy_wdata, busy_rdata;
   logic [IDX_W-1:0]       busy_waddr, busy_raddr;
   logic                   stk_we;
   logic [IDX_W-1:0]       stk_waddr, stk_raddr;
   logic [OFFSET_BITS-1:0] stk_wdata, stk_rdata;

   // Stack count port: one order is looked at per cycle.
   bba_pkg::order_type     ord_sel;
   logic [CIDX_W-1:0]      cidx;
   logic [CNT_W-1:0]       cnt_cur;
   logic                   cnt_we;
   logic [CNT_W-1:0]       cnt_wval;

   // Decoded request and effective configuration.
   logic [bba_pkg::SIZE_W-1:0]  req_size, size_m1;
   logic [bba_pkg::ADDR_W-1:0]  req_addr, rel_addr;
   bba_pkg::order_type          size_ord, lo_ord, hi_ord, req_ord;
   logic [OFFSET_BITS:0]        low_mask;
   logic [OFFSET_BITS-1:0]      mate;
   logic                        accept, rsp_free;

   bba_busy_ram #(.DEPTH_BITS(IDX_W)) u_busy (
      .clock   (clock),
      .wr_en   (busy_we),
      .wr_addr (busy_waddr),
      .wr_data (busy_wdata),
      .rd_addr (busy_raddr),
      .rd_data (busy_rdata)
   );

   bba_stack_ram #(.DEPTH_BITS(IDX_W), .WIDTH(OFFSET_BITS)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign req_size   = req_tdata[16:0];
   assign req_addr   = req_tdata[80:17];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rel_addr   = req_addr - base_ff;
   assign mate       = off_ff ^ (OFFSET_BITS'(1) << k_ff);

   // Both configured orders are clamped into the range the storage covers.
   always_comb begin
      if (min_ff < CFG_W_SO()) begin
         lo_ord = bba_pkg::ORD_W'(SMALLEST_ORDER);
      end else if (min_ff > CFG_W_OB()) begin
         lo_ord = bba_pkg::ORD_W'(OFFSET_BITS);
      end else begin
         lo_ord = bba_pkg::ORD_W'(min_ff);
      end
      if (max_ff < CFG_W_SO()) begin
         hi_ord = bba_pkg::ORD_W'(SMALLEST_ORDER);
      end else if (max_ff > CFG_W_OB()) begin
         hi_ord = bba_pkg::ORD_W'(OFFSET_BITS);
      end else begin
         hi_ord = bba_pkg::ORD_W'(max_ff);
      end
   end

   // Size is rounded up to a power of two: the order is one above the highest set bit of
   // size minus one, and sizes of zero and one give order zero before the lower clamp.
   always_comb begin
      size_m1  = req_size - bba_pkg::SIZE_W'(1);
      size_ord = '0;
      if (req_size > bba_pkg::SIZE_W'(1)) begin
         for (int j = 0; j < bba_pkg::SIZE_W; j++) begin
            if (size_m1[j]) begin
               size_ord = bba_pkg::ORD_W'(j + 1);
            end
         end
      end
      req_ord  = (size_ord < lo_ord) ? lo_ord : size_ord;
      low_mask = ((OFFSET_BITS+1)'(1) << req_ord) - (OFFSET_BITS+1)'(1);
   end

   // Which order's stack count is in use this cycle.
   always_comb begin
      case (state_ff)
         ST_SEARCH: ord_sel = t_ff;
         ST_SPLITB: ord_sel = k_ff - bba_pkg::ORD_W'(1);
         default:   ord_sel = k_ff;
      endcase
      cidx    = CIDX_W'(ord_sel - bba_pkg::ORD_W'(SMALLEST_ORDER));
      cnt_cur = cnt_ff[cidx];
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      o_in          = o_ff;
      t_in          = t_ff;
      k_in          = k_ff;
      off_in        = off_ff;
      scan_in       = scan_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      busy_we       = 1'b0;
      busy_waddr    = '0;
      busy_wdata    = 1'b0;
      busy_raddr    = '0;
      stk_we        = 1'b0;
      stk_waddr     = '0;
      stk_wdata     = '0;
      stk_raddr     = '0;
      cnt_we        = 1'b0;
      cnt_wval      = cnt_cur;

      case (state_ff)
         ST_CLEAR: begin
            busy_we    = 1'b1;
            busy_waddr = clr_ff;
            busy_wdata = 1'b1;
            clr_in     = clr_ff + IDX_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               o_in      = req_ord;
               t_in      = req_ord;
               k_in      = req_ord;
               status_in = bba_pkg::STATUS_DONE;
               grant_in  = '0;
               if (req_ord > hi_ord) begin
                  status_in = bba_pkg::STATUS_TOO_BIG;
                  state_in  = ST_RESP;
               end else if (req_tuser == bba_pkg::CMD_ALLOC) begin
                  state_in = ST_SEARCH;
               end else if ((rel_addr >> OFFSET_BITS) != '0) begin
                  // Addresses outside the region are ignored.
                  state_in = ST_RESP;
               end else begin
                  // A misaligned address drops the bits below the order.
                  off_in   = OFFSET_BITS'(rel_addr) & ~low_mask[OFFSET_BITS-1:0];
                  state_in = ST_FREERD;
               end
            end
         end
         ST_SEARCH: begin
            if (t_ff > hi_ord) begin
               status_in = bba_pkg::STATUS_NO_BLOCK;
               state_in  = ST_RESP;
            end else if (cnt_cur == '0) begin
               t_in = t_ff + bba_pkg::ORD_W'(1);
            end else begin
               stk_raddr = region_fn(t_ff) + IDX_W'(cnt_cur - CNT_W'(1));
               cnt_we    = 1'b1;
               cnt_wval  = cnt_cur - CNT_W'(1);
               state_in  = ST_POPRD;
            end
         end
         ST_POPRD: begin
            off_in     = stk_rdata;
            k_in       = t_ff;
            busy_we    = 1'b1;
            busy_waddr = bit_fn(t_ff, stk_rdata);
            busy_wdata = 1'b1;
            state_in   = ST_SPLITA;
         end
         ST_SPLITA: begin
            if (k_ff > o_ff) begin
               busy_we    = 1'b1;
               busy_waddr = bit_fn(k_ff - bba_pkg::ORD_W'(1), off_ff);
               busy_wdata = 1'b1;
               state_in   = ST_SPLITB;
            end else begin
               grant_in = base_ff + bba_pkg::ADDR_W'(off_ff);
               state_in = ST_RESP;
            end
         end
         ST_SPLITB: begin
            // The upper half goes free onto the stack one order down.
            busy_we    = 1'b1;
            busy_waddr = bit_fn(ord_sel, off_ff ^ (OFFSET_BITS'(1) << ord_sel));
            busy_wdata = 1'b0;
            if (cnt_cur < blocks_fn(ord_sel)) begin
               stk_we    = 1'b1;
               stk_waddr = region_fn(ord_sel) + IDX_W'(cnt_cur);
               stk_wdata = off_ff ^ (OFFSET_BITS'(1) << ord_sel);
               cnt_we    = 1'b1;
               cnt_wval  = cnt_cur + CNT_W'(1);
            end
            k_in     = ord_sel;
            state_in = ST_SPLITA;
         end
         ST_FREERD: begin
            busy_raddr = bit_fn(o_ff, off_ff);
            state_in   = ST_FREECHK;
         end
         ST_FREECHK: begin
            // A block that is already free is a double free and is ignored.
            state_in = busy_rdata ? ST_M0 : ST_RESP;
         end
         ST_M0: begin
            busy_we    = 1'b1;
            busy_waddr = bit_fn(k_ff, off_ff);
            busy_wdata = 1'b0;
            busy_raddr = bit_fn(k_ff, mate);
            if (k_ff == hi_ord) begin
               if (cnt_cur < blocks_fn(k_ff)) begin
                  stk_we    = 1'b1;
                  stk_waddr = region_fn(k_ff) + IDX_W'(cnt_cur);
                  stk_wdata = off_ff;
                  cnt_we    = 1'b1;
                  cnt_wval  = cnt_cur + CNT_W'(1);
               end
               state_in = ST_RESP;
            end else begin
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            if (busy_rdata) begin
               if (cnt_cur < blocks_fn(k_ff)) begin
                  stk_we    = 1'b1;
                  stk_waddr = region_fn(k_ff) + IDX_W'(cnt_cur);
                  stk_wdata = off_ff;
                  cnt_we    = 1'b1;
                  cnt_wval  = cnt_cur + CNT_W'(1);
               end
               state_in = ST_RESP;
            end else begin
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // A buddy flagged free but absent from its stack is still merged.
            if (scan_ff < cnt_cur) begin
               stk_raddr = region_fn(k_ff) + IDX_W'(scan_ff);
               state_in  = ST_SCANCHK;
            end else begin
               state_in = ST_MF1;
            end
         end
         ST_SCANCHK: begin
            if (stk_rdata == mate) begin
               stk_raddr = region_fn(k_ff) + IDX_W'(cnt_cur - CNT_W'(1));
               state_in  = ST_TOPWR;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_TOPWR: begin
            // The top entry fills the slot the buddy leaves.
            stk_we    = 1'b1;
            stk_waddr = region_fn(k_ff) + IDX_W'(scan_ff);
            stk_wdata = stk_rdata;
            cnt_we    = 1'b1;
            cnt_wval  = cnt_cur - CNT_W'(1);
            state_in  = ST_MF1;
         end
         ST_MF1: begin
            busy_we    = 1'b1;
            busy_waddr = bit_fn(k_ff, mate);
            busy_wdata = 1'b1;
            state_in   = ST_MF2;
         end
         ST_MF2: begin
            busy_we    = 1'b1;
            busy_waddr = bit_fn(k_ff, off_ff);
            busy_wdata = 1'b1;
            off_in     = off_ff & ~(OFFSET_BITS'(1) << k_ff);
            k_in       = k_ff + bba_pkg::ORD_W'(1);
            state_in   = ST_M0;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = grant_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         min_ff       <= bba_pkg::CFG_ORD_W'(6);
         max_ff       <= bba_pkg::CFG_ORD_W'(16);
         for (int i = 0; i < ORDER_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            cnt_ff[cidx] <= cnt_wval;
         end
         if (csr_we) begin
            case (csr_index)
               bba_pkg::CSR_BASE_ADDRESS: base_ff <= csr_wdata;
               bba_pkg::CSR_MIN_ORDER:    min_ff  <= csr_wdata[4:0];
               bba_pkg::CSR_MAX_ORDER:    max_ff  <= csr_wdata[4:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      o_ff          <= o_in;
      t_ff          <= t_in;
      k_ff          <= k_in;
      off_ff        <= off_in;
      scan_ff       <= scan_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // A response beat only appears when the sequencer hands one over.
   `BBA_CHECK(a_rsp_from_seq, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP, "response outside the response step")
   // The buddy scan never reads beyond the live part of a stack.
   `BBA_IMPLIES(a_scan_in_range, clock, reset,
      state_ff == ST_SCANCHK, scan_ff < cnt_cur, "buddy scan beyond stack top")
   // Removing a buddy needs a non-empty stack.
   `BBA_IMPLIES(a_remove_nonempty, clock, reset,
      state_ff == ST_TOPWR, cnt_cur != '0, "buddy removed from an empty stack")

endmodule
